FILE: rtl/dpc_pkg.sv
// Shared types and constants for the dock pose P controller.
package dpc_pkg;

    localparam int SETTLE_W = 3;
    localparam logic [SETTLE_W-1:0] SETTLE_MAX = 3'd7;

    localparam logic signed [17:0] PI_Q13     = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [23:0] ABORT_Q16  = -24'sd65536;

    localparam logic [15:0] LINEAR_GAIN_RST      = 16'd8192;
    localparam logic [15:0] SLOW_LINEAR_GAIN_RST = 16'd14336;
    localparam logic [15:0] POINT_TOLERANCE_RST  = 16'd328;
    localparam logic [15:0] ANGULAR_GAIN_RST     = 16'd10240;
    localparam logic [14:0] ANGULAR_MAX_RST      = 15'd8192;
    localparam logic [14:0] ANGLE_TOLERANCE_RST  = 15'd82;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_GOAL = 2'd1,
        REQ_POSE = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_MOVE   = 2'd1,
        PH_ROTATE = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        CFG_LINEAR_GAIN      = 3'd0,
        CFG_SLOW_LINEAR_GAIN = 3'd1,
        CFG_POINT_TOLERANCE  = 3'd2,
        CFG_ANGULAR_GAIN     = 3'd3,
        CFG_ANGULAR_MAX      = 3'd4,
        CFG_ANGLE_TOLERANCE  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] heading;
        logic               slow_profile;
    } req_item_t;

    typedef struct packed {
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [15:0] vel_turn;
        logic               goal_reached;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] linear_gain;
        logic [15:0] slow_linear_gain;
        logic [15:0] point_tolerance;
        logic [15:0] angular_gain;
        logic [14:0] angular_max_speed;
        logic [14:0] angle_tolerance;
    } cfg_t;

    typedef struct packed {
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic               at_point;
        logic signed [15:0] vel_turn;
        logic               in_band;
    } law_t;

endpackage

FILE: rtl/dpc_law.sv
// Control law: position and heading commands from the held goal and pose.
module dpc_law
    import dpc_pkg::*;
(
    input  cfg_t               cfg,
    input  logic               slow,
    input  logic signed [23:0] goal_x,
    input  logic signed [23:0] goal_y,
    input  logic signed [15:0] goal_heading,
    input  logic signed [23:0] pose_x,
    input  logic signed [23:0] pose_y,
    input  logic signed [15:0] pose_heading,
    output law_t               law
);

    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [16:0] gain;
    logic signed [41:0] prod_x;
    logic signed [41:0] prod_y;
    logic signed [29:0] rnd_x;
    logic signed [29:0] rnd_y;
    logic signed [49:0] dsq_x;
    logic signed [49:0] dsq_y;
    logic [50:0]        dist_sq;
    logic [31:0]        tol_sq;
    logic signed [17:0] err_raw;
    logic signed [17:0] err;
    logic [17:0]        mag;
    logic [33:0]        prod_t;
    logic [21:0]        rate_raw;
    logic [14:0]        rate;

    function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
        if (v > 30'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -30'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    always_comb
    begin
        dx     = 25'(goal_x) - 25'(pose_x);
        dy     = 25'(goal_y) - 25'(pose_y);
        gain   = $signed({1'b0, slow ? cfg.slow_linear_gain : cfg.linear_gain});
        prod_x = 42'(dx) * 42'(gain);
        prod_y = 42'(dy) * 42'(gain);
        // Round half up onto Q8.16 with a floor shift.
        rnd_x  = 30'((prod_x + 42'sd2048) >>> 12);
        rnd_y  = 30'((prod_y + 42'sd2048) >>> 12);
        dsq_x  = 50'(dx) * 50'(dx);
        dsq_y  = 50'(dy) * 50'(dy);
        dist_sq = {1'b0, $unsigned(dsq_x)} + {1'b0, $unsigned(dsq_y)};
        tol_sq  = 32'(cfg.point_tolerance) * 32'(cfg.point_tolerance);

        err_raw = 18'(goal_heading) - 18'(pose_heading);
        if (err_raw >= PI_Q13) begin
            err = err_raw - TWO_PI_Q13;
        end else if (err_raw <= -PI_Q13) begin
            err = err_raw + TWO_PI_Q13;
        end else begin
            err = err_raw;
        end
        mag      = err[17] ? $unsigned(-err) : $unsigned(err);
        prod_t   = 34'(mag) * 34'(cfg.angular_gain);
        rate_raw = 22'((prod_t + 34'd2048) >> 12);
        rate     = (rate_raw > 22'(cfg.angular_max_speed)) ? cfg.angular_max_speed
                                                            : rate_raw[14:0];

        law.vel_x    = sat24(rnd_x);
        law.vel_y    = sat24(rnd_y);
        law.at_point = dist_sq <= 51'(tol_sq);
        law.vel_turn = err[17] ? -$signed({1'b0, rate}) : $signed({1'b0, rate});
        law.in_band  = mag < 18'(cfg.angle_tolerance);
    end

endmodule

FILE: rtl/dock_pose_p_controller.sv
// Top level of the dock pose P controller: request intake, state and command output.
//
// Usage. Requests arrive on req_valid / req_stall with a req_item_t payload; an item
// is taken at a clock edge where req_valid is high and req_stall is low. A goal item
// stores the target pose and the gain profile, a pose item stores the measured pose,
// and a control tick produces one command item on cmd_valid / cmd_stall while a goal
// is active. Goal and pose items produce no command, and neither does a tick with no
// goal active or an unknown request type.
// Gains and tolerances sit behind cfg_valid / cfg_ready (always ready), indexed by
// cfg_index; the user writes them only while idle; the block does not enforce this.
// Timing. An item is registered on intake and handled from the intake register; a
// tick's command is then registered in the command register. Every item is handled by
// one pass of the control law between the intake register and the command register,
// so one item per cycle is sustained while cmd_stall holds no pending command.
// Stall. While a command waits under cmd_stall the handled item stays in the intake
// register and req_stall rises; nothing is lost or repeated.
// Reset. rst_n clears goal, pose, mode and settle counter, loads the default gains
// and leaves both channels empty.
module dock_pose_p_controller
    import dpc_pkg::*;
#(
    parameter int SETTLE_TICKS = 6
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      cmd_valid,
    input  logic      cmd_stall,
    output cmd_item_t cmd,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    req_item_t          in_reg;
    logic               cmd_valid_reg;
    logic               cmd_valid_next;
    cmd_item_t          cmd_reg;
    cmd_item_t          cmd_next;

    // Controller state and its next values.
    logic signed [23:0] goal_x_reg, goal_x_next;
    logic signed [23:0] goal_y_reg, goal_y_next;
    logic signed [15:0] goal_heading_reg, goal_heading_next;
    logic signed [23:0] pose_x_reg, pose_x_next;
    logic signed [23:0] pose_y_reg, pose_y_next;
    logic signed [15:0] pose_heading_reg, pose_heading_next;
    phase_t             phase_reg, phase_next;
    logic               goal_active_reg, goal_active_next;
    logic               use_slow_reg, use_slow_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;

    logic                out_block;
    logic                handle;
    logic                emit;
    logic                is_abort;
    logic [SETTLE_W-1:0] settle_inc;
    logic                settled;
    law_t                law;

    assign cfg_ready = 1'b1;
    assign out_block = cmd_valid_reg && cmd_stall;
    assign handle    = in_valid_reg && !out_block;
    assign req_stall = in_valid_reg && out_block;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    assign is_abort = (in_reg.pos_x == ABORT_Q16) && (in_reg.pos_y == ABORT_Q16);

    // The settle counter saturates at SETTLE_MAX; the goal completes once it reaches SETTLE_TICKS.
    assign settle_inc = !law.in_band ? '0 :
                        (settle_reg == SETTLE_MAX) ? SETTLE_MAX
                                                   : settle_reg + SETTLE_W'(1);
    assign settled    = settle_inc >= SETTLE_W'(SETTLE_TICKS);

    dpc_law u_law (
        .cfg          (cfg_reg),
        .slow         (use_slow_reg),
        .goal_x       (goal_x_reg),
        .goal_y       (goal_y_reg),
        .goal_heading (goal_heading_reg),
        .pose_x       (pose_x_reg),
        .pose_y       (pose_y_reg),
        .pose_heading (pose_heading_reg),
        .law          (law)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.linear_gain       <= LINEAR_GAIN_RST;
            cfg_reg.slow_linear_gain  <= SLOW_LINEAR_GAIN_RST;
            cfg_reg.point_tolerance   <= POINT_TOLERANCE_RST;
            cfg_reg.angular_gain      <= ANGULAR_GAIN_RST;
            cfg_reg.angular_max_speed <= ANGULAR_MAX_RST;
            cfg_reg.angle_tolerance   <= ANGLE_TOLERANCE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LINEAR_GAIN:      cfg_reg.linear_gain       <= cfg_data;
                CFG_SLOW_LINEAR_GAIN: cfg_reg.slow_linear_gain  <= cfg_data;
                CFG_POINT_TOLERANCE:  cfg_reg.point_tolerance   <= cfg_data;
                CFG_ANGULAR_GAIN:     cfg_reg.angular_gain      <= cfg_data;
                CFG_ANGULAR_MAX:      cfg_reg.angular_max_speed <= cfg_data[14:0];
                CFG_ANGLE_TOLERANCE:  cfg_reg.angle_tolerance   <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // Intake register: refills whenever the handled item moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (!req_stall) begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid) begin
            in_reg <= req;
        end
    end

    // Next state of the controller for the item being handled.
    always_comb
    begin
        goal_x_next       = goal_x_reg;
        goal_y_next       = goal_y_reg;
        goal_heading_next = goal_heading_reg;
        pose_x_next       = pose_x_reg;
        pose_y_next       = pose_y_reg;
        pose_heading_next = pose_heading_reg;
        phase_next        = phase_reg;
        goal_active_next  = goal_active_reg;
        use_slow_next     = use_slow_reg;
        settle_next       = settle_reg;
        if (handle) begin
            unique case (in_reg.req_type)
                REQ_GOAL:
                begin
                    if (is_abort) begin
                        phase_next = PH_IDLE;
                    end else begin
                        goal_x_next       = in_reg.pos_x;
                        goal_y_next       = in_reg.pos_y;
                        goal_heading_next = in_reg.heading;
                        use_slow_next     = in_reg.slow_profile;
                        phase_next        = PH_MOVE;
                        goal_active_next  = 1'b1;
                        settle_next       = '0;
                    end
                end
                REQ_POSE:
                begin
                    pose_x_next       = in_reg.pos_x;
                    pose_y_next       = in_reg.pos_y;
                    pose_heading_next = in_reg.heading;
                end
                REQ_TICK:
                begin
                    if (goal_active_reg) begin
                        unique case (phase_reg)
                            PH_MOVE:
                            begin
                                if (law.at_point) begin
                                    phase_next = PH_ROTATE;
                                end
                            end
                            PH_ROTATE:
                            begin
                                settle_next = settle_inc;
                                if (settled) begin
                                    goal_active_next = 1'b0;
                                    phase_next       = PH_IDLE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Command produced by the item being handled.
    always_comb
    begin
        emit     = handle && (in_reg.req_type == REQ_TICK) && goal_active_reg;
        cmd_next = '0;
        unique case (phase_reg)
            PH_MOVE:
            begin
                if (!law.at_point) begin
                    cmd_next.vel_x = law.vel_x;
                    cmd_next.vel_y = law.vel_y;
                end
            end
            PH_ROTATE:
            begin
                if (settled) begin
                    cmd_next.goal_reached = 1'b1;
                end else begin
                    cmd_next.vel_turn = law.vel_turn;
                end
            end
            default: ;
        endcase

        if (emit) begin
            cmd_valid_next = 1'b1;
        end else if (!cmd_stall) begin
            cmd_valid_next = 1'b0;
        end else begin
            cmd_valid_next = cmd_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            goal_x_reg       <= '0;
            goal_y_reg       <= '0;
            goal_heading_reg <= '0;
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            pose_heading_reg <= '0;
            phase_reg        <= PH_IDLE;
            goal_active_reg  <= 1'b0;
            use_slow_reg     <= 1'b0;
            settle_reg       <= '0;
            cmd_valid_reg    <= 1'b0;
        end else begin
            goal_x_reg       <= goal_x_next;
            goal_y_reg       <= goal_y_next;
            goal_heading_reg <= goal_heading_next;
            pose_x_reg       <= pose_x_next;
            pose_y_reg       <= pose_y_next;
            pose_heading_reg <= pose_heading_next;
            phase_reg        <= phase_next;
            goal_active_reg  <= goal_active_next;
            use_slow_reg     <= use_slow_next;
            settle_reg       <= settle_next;
            cmd_valid_reg    <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            cmd_reg <= cmd_next;
        end
    end

    // A moving or rotating mode only exists while a goal is active.
    a_mode_needs_goal: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> goal_active_reg)
        else $error("mode set without an active goal");

    // The completing command carries no motion.
    a_reached_is_still: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.goal_reached) |->
            (cmd.vel_x == 24'sd0 && cmd.vel_y == 24'sd0 && cmd.vel_turn == 16'sd0))
        else $error("goal_reached with nonzero velocity");

    // Completing a goal leaves the controller inactive.
    a_reached_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && cmd_next.goal_reached) |=> (!goal_active_reg && phase_reg == PH_IDLE))
        else $error("goal still active after completion");

    // A pending command is never overwritten while it is stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid_reg && cmd_stall) |-> !emit)
        else $error("command produced while output is stalled");

endmodule
